// ===== hw/rtl/nsp_pkg.sv =====
// ----------------------------------------------------------------------------
// nsp_pkg: shared types and constants of the NMEA sentence parser
// Character codes, result kinds, sentence type codes and the summary and
// result records that pass between the parser state and the result former.
// ----------------------------------------------------------------------------
package nsp_pkg;

    typedef logic [7:0] t_byte;

    // ASCII characters the parser reacts to
    localparam t_byte CH_DOLLAR = 8'h24;
    localparam t_byte CH_STAR   = 8'h2A;
    localparam t_byte CH_COMMA  = 8'h2C;
    localparam t_byte CH_LF     = 8'h0A;
    localparam t_byte CH_ZERO   = 8'h30;
    localparam t_byte CH_A      = 8'h41;
    localparam t_byte CH_C      = 8'h43;
    localparam t_byte CH_G      = 8'h47;
    localparam t_byte CH_M      = 8'h4D;
    localparam t_byte CH_N      = 8'h4E;
    localparam t_byte CH_P      = 8'h50;
    localparam t_byte CH_R      = 8'h52;

    // result kinds
    localparam logic [2:0] KIND_BAD_CK = 3'd0;
    localparam logic [2:0] KIND_FEW    = 3'd1;
    localparam logic [2:0] KIND_OTHER  = 3'd2;
    localparam logic [2:0] KIND_RMC    = 3'd3;
    localparam logic [2:0] KIND_GGA    = 3'd4;

    // sentence type tracking
    localparam logic [1:0] ST_OTHER  = 2'd0;
    localparam logic [1:0] ST_PREFIX = 2'd1;
    localparam logic [1:0] ST_RMC    = 2'd2;
    localparam logic [1:0] ST_GGA    = 2'd3;

    // checksum phases
    localparam logic [1:0] CK_BODY = 2'd0;
    localparam logic [1:0] CK_HEX  = 2'd1;
    localparam logic [1:0] CK_DONE = 2'd2;

    // state of a finished sentence, as seen at its line feed
    typedef struct packed {
        logic       ck_ok;
        logic       few_fields;
        logic [1:0] stype;
        logic       time_ok;
        logic       date_ok;
        logic       stat_a;
        t_byte      hour;
        t_byte      minute;
        t_byte      second;
        t_byte      day;
        t_byte      month;
        t_byte      year;
        t_byte      fix;
        t_byte      sats;
    } t_summary;

    typedef struct packed {
        logic [2:0] kind;
        logic       status_active;
        logic       time_ok;
        t_byte      hour;
        t_byte      minute;
        t_byte      second;
        logic       date_ok;
        t_byte      day;
        t_byte      month;
        t_byte      year;
        t_byte      fix;
        t_byte      sats;
    } t_result;

    // {valid, value} of an ASCII hex digit
    function automatic logic [4:0] hex_value(input t_byte c);
        logic [4:0] h;
        h = 5'd0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h = {1'b1, 4'(c - 8'h30)};
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h = {1'b1, 4'(c - 8'h37)};
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h = {1'b1, 4'(c - 8'h57)};
        end
        return h;
    endfunction

endpackage

// ===== hw/rtl/nsp_result.sv =====
// ----------------------------------------------------------------------------
// nsp_result: result former
// Classifies a finished sentence and masks the decoded fields that do not
// apply to its kind.
// ----------------------------------------------------------------------------
module nsp_result (
    input  nsp_pkg::t_summary i_sum,
    output nsp_pkg::t_result  o_res
);
    import nsp_pkg::*;

    logic [2:0] kind;

    always_comb begin
        priority if (!i_sum.ck_ok) begin
            kind = KIND_BAD_CK;
        end else if (i_sum.stype != ST_RMC && i_sum.stype != ST_GGA) begin
            kind = KIND_OTHER;
        end else if (i_sum.few_fields) begin
            kind = KIND_FEW;
        end else if (i_sum.stype == ST_RMC) begin
            kind = KIND_RMC;
        end else begin
            kind = KIND_GGA;
        end
    end

    always_comb begin
        o_res      = '0;
        o_res.kind = kind;
        if (kind == KIND_RMC) begin
            // nothing beyond the status unless active, no date without time
            if (i_sum.stat_a) begin
                o_res.status_active = 1'b1;
                if (i_sum.time_ok) begin
                    o_res.time_ok = 1'b1;
                    o_res.hour    = i_sum.hour;
                    o_res.minute  = i_sum.minute;
                    o_res.second  = i_sum.second;
                    if (i_sum.date_ok) begin
                        o_res.date_ok = 1'b1;
                        o_res.day     = i_sum.day;
                        o_res.month   = i_sum.month;
                        o_res.year    = i_sum.year;
                    end
                end
            end
        end else if (kind == KIND_GGA) begin
            if (i_sum.time_ok) begin
                o_res.time_ok = 1'b1;
                o_res.hour    = i_sum.hour;
                o_res.minute  = i_sum.minute;
                o_res.second  = i_sum.second;
            end
            o_res.fix  = i_sum.fix;
            o_res.sats = i_sum.sats;
        end
    end

endmodule

// ===== hw/rtl/nmea_sentence_parser.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_parser: NMEA 0183 sentence parser
// Byte-wide parser for RMC and GGA sentences with checksum check.
// ----------------------------------------------------------------------------
// Takes one received character per item and accepts a new item every cycle.
// Each byte is registered, then the sentence state (checksum XOR, received
// hex checksum, field index, decoded digits) is updated from it. The line
// feed that ends a sentence presents one result item through the input
// register and then the output register; no other byte yields anything.
// Input stalls only when a line feed is due while the output register still
// holds an untaken result. Bytes beyond MAX_LINE-1 in a sentence are dropped
// and the sentence reports a checksum failure; commas beyond the first
// MAX_FIELDS-1 belong to the last field.
// ----------------------------------------------------------------------------
module nmea_sentence_parser #(
    parameter int MAX_LINE   = 128,
    parameter int MAX_FIELDS = 20
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_rx_byte,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [2:0] o_sentence_kind,
    output logic       o_status_active,
    output logic       o_time_ok,
    output logic [7:0] o_hour,
    output logic [7:0] o_minute,
    output logic [7:0] o_second,
    output logic       o_date_ok,
    output logic [7:0] o_day_of_month,
    output logic [7:0] o_month_number,
    output logic [7:0] o_year_in_century,
    output logic [7:0] o_fix_type,
    output logic [7:0] o_satellite_count
);
    import nsp_pkg::*;

    localparam int CW = $clog2(MAX_LINE);
    localparam int FW = $clog2(MAX_FIELDS);
    localparam logic [CW-1:0] MAX_CC  = CW'(MAX_LINE - 1);
    localparam logic [FW-1:0] LAST_FI = FW'(MAX_FIELDS - 1);

    // input register
    logic  r_in_valid;
    t_byte r_in_byte;

    // sentence state
    logic          r_in_sentence, n_in_sentence;
    logic [CW-1:0] r_cc, n_cc;
    t_byte         r_xor, n_xor;
    logic [1:0]    r_ck_phase, n_ck_phase;
    t_byte         r_ck_recv, n_ck_recv;
    logic [FW-1:0] r_field_idx, n_field_idx;
    logic [2:0]    r_cif, n_cif;
    logic [1:0]    r_stype, n_stype;
    t_byte         r_pair [6];
    t_byte         n_pair [6];
    t_byte         r_fix, n_fix;
    t_byte         r_sats, n_sats;
    logic          r_alive, n_alive;
    logic          r_time_ok, n_time_ok;
    logic          r_date_ok, n_date_ok;
    logic          r_stat_a, n_stat_a;
    logic          r_ovf, n_ovf;

    // output register
    logic    r_out_valid;
    t_result r_out;

    t_byte    c;
    logic     emits;
    logic     proc_fire;
    t_summary sum;
    t_result  res;

    assign c         = r_in_byte;
    assign emits     = r_in_sentence && (c == CH_LF);
    assign proc_fire = r_in_valid && !(emits && r_out_valid && i_out_stall);
    assign o_in_stall = r_in_valid && !proc_fire;

    always_comb begin
        logic          start;
        logic [CW-1:0] p;
        logic [4:0]    h;
        t_byte         d;
        logic          is_dig;
        logic [11:0]   v;
        logic [2:0]    pidx;
        logic          pair_fld;
        logic [1:0]    pbase;

        start = (c == CH_DOLLAR);
        p      = '0;
        h      = hex_value(c);
        d      = c - CH_ZERO;
        is_dig = (c >= CH_ZERO) && (c <= 8'h39);
        v      = 12'd0;
        pidx   = 3'd0;
        pair_fld = 1'b0;
        pbase  = 2'd0;

        n_in_sentence = r_in_sentence;
        if (start) begin
            n_cc        = '0;
            n_xor       = '0;
            n_ck_phase  = CK_BODY;
            n_ck_recv   = '0;
            n_field_idx = '0;
            n_cif       = '0;
            n_stype     = ST_PREFIX;
            n_pair      = '{default: '0};
            n_fix       = '0;
            n_sats      = '0;
            n_alive     = 1'b1;
            n_time_ok   = 1'b0;
            n_date_ok   = 1'b0;
            n_stat_a    = 1'b0;
            n_ovf       = 1'b0;
        end else begin
            n_cc        = r_cc;
            n_xor       = r_xor;
            n_ck_phase  = r_ck_phase;
            n_ck_recv   = r_ck_recv;
            n_field_idx = r_field_idx;
            n_cif       = r_cif;
            n_stype     = r_stype;
            n_pair      = r_pair;
            n_fix       = r_fix;
            n_sats      = r_sats;
            n_alive     = r_alive;
            n_time_ok   = r_time_ok;
            n_date_ok   = r_date_ok;
            n_stat_a    = r_stat_a;
            n_ovf       = r_ovf;
        end

        if (start || r_in_sentence) begin
            if (n_cc < MAX_CC) begin
                p    = n_cc;
                n_cc = n_cc + CW'(1);

                // "$G[NP]RMC" / "$G[NP]GGA" prefix match
                priority if (p == CW'(1)) begin
                    if (c != CH_G) n_stype = ST_OTHER;
                end else if (p == CW'(2)) begin
                    if (c != CH_N && c != CH_P) n_stype = ST_OTHER;
                end else if (p == CW'(3)) begin
                    if (n_stype == ST_PREFIX) begin
                        n_stype = (c == CH_R) ? ST_RMC : (c == CH_G) ? ST_GGA : ST_OTHER;
                    end
                end else if (p == CW'(4)) begin
                    if ((n_stype == ST_RMC && c != CH_M) || (n_stype == ST_GGA && c != CH_G))
                        n_stype = ST_OTHER;
                end else if (p == CW'(5)) begin
                    if ((n_stype == ST_RMC && c != CH_C) || (n_stype == ST_GGA && c != CH_A))
                        n_stype = ST_OTHER;
                end else begin
                end

                if (p != '0) begin
                    if (n_ck_phase == CK_BODY) begin
                        if (c == CH_STAR) n_ck_phase = CK_HEX;
                        else n_xor = n_xor ^ c;
                    end else if (n_ck_phase == CK_HEX) begin
                        if (h[4]) n_ck_recv = {n_ck_recv[3:0], h[3:0]};
                        else n_ck_phase = CK_DONE;
                    end
                end

                if (c == CH_COMMA && n_field_idx < LAST_FI) begin
                    n_field_idx = n_field_idx + FW'(1);
                    n_cif       = '0;
                    n_alive     = 1'b1;
                end else begin
                    if (n_field_idx == FW'(1)) begin
                        pair_fld = 1'b1;
                        pbase    = 2'd0;
                    end else if (n_field_idx == FW'(9)) begin
                        pair_fld = 1'b1;
                        pbase    = 2'd3;
                    end
                    // hhmmss / ddmmyy: two digits per value, no digit check
                    if (pair_fld && n_cif <= 3'd5) begin
                        pidx = {1'b0, n_cif[2:1]} + {1'b0, pbase};
                        if (!n_cif[0]) n_pair[pidx] = {d[4:0], 3'b000} + {d[6:0], 1'b0};
                        else n_pair[pidx] = n_pair[pidx] + d;
                        if (n_cif == 3'd5) begin
                            if (pbase == 2'd0) n_time_ok = 1'b1;
                            else n_date_ok = 1'b1;
                        end
                    end
                    if (n_field_idx == FW'(2) && n_cif == '0 && c == CH_A) n_stat_a = 1'b1;
                    if (n_field_idx == FW'(6) || n_field_idx == FW'(7)) begin
                        if (n_alive && is_dig) begin
                            v = (n_field_idx == FW'(6)) ? {1'b0, n_fix, 3'b000} +
                                {3'b000, n_fix, 1'b0} : {1'b0, n_sats, 3'b000} +
                                {3'b000, n_sats, 1'b0};
                            v = v + {8'd0, d[3:0]};
                            if (n_field_idx == FW'(6))
                                n_fix = (v > 12'd255) ? 8'hFF : v[7:0];
                            else
                                n_sats = (v > 12'd255) ? 8'hFF : v[7:0];
                        end else begin
                            n_alive = 1'b0;
                        end
                    end
                    // only positions 0..5 matter, so the count saturates at 6
                    if (n_cif < 3'd6) n_cif = n_cif + 3'd1;
                end
            end else begin
                n_ovf = 1'b1;
            end
            n_in_sentence = (c != CH_LF);
        end
    end

    always_comb begin
        sum            = '0;
        sum.ck_ok      = !n_ovf && (n_ck_phase != CK_BODY) && (n_xor == n_ck_recv);
        sum.few_fields = (n_field_idx < FW'(9));
        sum.stype      = n_stype;
        sum.time_ok    = n_time_ok;
        sum.date_ok    = n_date_ok;
        sum.stat_a     = n_stat_a;
        sum.hour       = n_pair[0];
        sum.minute     = n_pair[1];
        sum.second     = n_pair[2];
        sum.day        = n_pair[3];
        sum.month      = n_pair[4];
        sum.year       = n_pair[5];
        sum.fix        = n_fix;
        sum.sats       = n_sats;
    end

    nsp_result u_result (
        .i_sum (sum),
        .o_res (res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in_valid && !o_in_stall) begin
            r_in_valid <= 1'b1;
        end else if (proc_fire) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && !o_in_stall) begin
            r_in_byte <= i_rx_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_sentence <= 1'b0;
            r_cc          <= '0;
            r_xor         <= '0;
            r_ck_phase    <= CK_BODY;
            r_ck_recv     <= '0;
            r_field_idx   <= '0;
            r_cif         <= '0;
            r_stype       <= ST_OTHER;
            r_pair        <= '{default: '0};
            r_fix         <= '0;
            r_sats        <= '0;
            r_alive       <= 1'b0;
            r_time_ok     <= 1'b0;
            r_date_ok     <= 1'b0;
            r_stat_a      <= 1'b0;
            r_ovf         <= 1'b0;
        end else if (proc_fire) begin
            r_in_sentence <= n_in_sentence;
            r_cc          <= n_cc;
            r_xor         <= n_xor;
            r_ck_phase    <= n_ck_phase;
            r_ck_recv     <= n_ck_recv;
            r_field_idx   <= n_field_idx;
            r_cif         <= n_cif;
            r_stype       <= n_stype;
            r_pair        <= n_pair;
            r_fix         <= n_fix;
            r_sats        <= n_sats;
            r_alive       <= n_alive;
            r_time_ok     <= n_time_ok;
            r_date_ok     <= n_date_ok;
            r_stat_a      <= n_stat_a;
            r_ovf         <= n_ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc_fire && emits) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc_fire && emits) begin
            r_out <= res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_sentence_kind   = r_out.kind;
    assign o_status_active   = r_out.status_active;
    assign o_time_ok         = r_out.time_ok;
    assign o_hour            = r_out.hour;
    assign o_minute          = r_out.minute;
    assign o_second          = r_out.second;
    assign o_date_ok         = r_out.date_ok;
    assign o_day_of_month    = r_out.day;
    assign o_month_number    = r_out.month;
    assign o_year_in_century = r_out.year;
    assign o_fix_type        = r_out.fix;
    assign o_satellite_count = r_out.sats;

    a_ck_phase_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ck_phase != 2'd3)
        else $error("checksum phase took an unused code");

    a_cc_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cc <= MAX_CC)
        else $error("character count passed the line limit");

    a_field_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_field_idx <= LAST_FI)
        else $error("field index passed the field limit");

    a_rmc_inactive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_sentence_kind == KIND_RMC && !o_status_active
        |-> !o_time_ok && !o_date_ok && o_hour == 8'd0)
        else $error("inactive RMC item carries time or date");

    a_plain_kinds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_sentence_kind == KIND_BAD_CK || o_sentence_kind == KIND_FEW ||
        o_sentence_kind == KIND_OTHER)
        |-> !o_status_active && !o_time_ok && !o_date_ok && o_fix_type == 8'd0)
        else $error("non-decoded item carries field data");

    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> r_in_valid && emits && r_out_valid && i_out_stall)
        else $error("input stalled without a blocked line feed");

endmodule

// ===== dv/nmea_sentence_parser_tb.sv =====
// ----------------------------------------------------------------------------
// nmea_sentence_parser_tb: self-checking testbench of the NMEA sentence parser
// Feeds RMC, GGA and other sentences byte by byte, well-formed and broken,
// with random gaps and output stalls, and checks every result item against
// a cycle-free predictor of the sentence decoder.
// ----------------------------------------------------------------------------
module nmea_sentence_parser_tb;
    import nsp_pkg::*;

    localparam int MAX_LINE     = 128;
    localparam int MAX_FIELDS   = 20;
    localparam int MIN_FIELDS   = 10;
    localparam int QUIET_LIMIT  = 2000;
    localparam int DRAIN_CYCLES = 20;
    localparam int LONG_HOLD    = 400;

    localparam t_byte CH_CR = 8'h0D;

    // decoded value slots
    localparam int V_HOUR = 0;
    localparam int V_MIN  = 1;
    localparam int V_SEC  = 2;
    localparam int V_DAY  = 3;
    localparam int V_MON  = 4;
    localparam int V_YEAR = 5;
    localparam int V_FIX  = 6;
    localparam int V_SATS = 7;
    localparam int V_RUN  = 8;

    localparam logic [3:0] F_TIME = 4'b0001;
    localparam logic [3:0] F_DATE = 4'b0010;
    localparam logic [3:0] F_STAT = 4'b0100;
    localparam logic [3:0] F_LONG = 4'b1000;

    // comma field positions
    localparam int FLD_TIME   = 1;
    localparam int FLD_STATUS = 2;
    localparam int FLD_FIX    = 6;
    localparam int FLD_SATS   = 7;
    localparam int FLD_DATE   = 9;

    typedef enum {TAIL_GOOD, TAIL_WRONG, TAIL_NO_STAR, TAIL_LOWER, TAIL_EXTRA_DIGIT,
                  TAIL_ONE_DIGIT} t_tail;
    typedef enum {FR_CLOCK, FR_FLAG, FR_COUNT, FR_FILL} t_field_role;

    typedef struct {
        t_byte ch;
        bit    drain_first;
    } t_uart_item;

    logic       i_clk             = 1'b0;
    logic       i_rst_n           = 1'b0;
    logic       i_in_valid        = 1'b0;
    logic [7:0] i_rx_byte         = 8'd0;
    logic       i_out_stall       = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic [2:0] o_sentence_kind;
    logic       o_status_active;
    logic       o_time_ok;
    logic [7:0] o_hour;
    logic [7:0] o_minute;
    logic [7:0] o_second;
    logic       o_date_ok;
    logic [7:0] o_day_of_month;
    logic [7:0] o_month_number;
    logic [7:0] o_year_in_century;
    logic [7:0] o_fix_type;
    logic [7:0] o_satellite_count;

    // sentence decoder state
    logic       in_line    = 1'b0;
    t_byte      line_len   = 8'd0;
    t_byte      ck_sum     = 8'd0;
    t_byte      ck_seen    = 8'd0;
    t_byte      fld_pos    = 8'd0;
    logic [1:0] ck_state   = CK_BODY;
    logic [1:0] msg_type   = ST_OTHER;
    logic [4:0] fld_idx    = 5'd0;
    logic [3:0] line_flags = 4'd0;
    t_byte      fld_val [10] = '{default: 8'd0};

    t_result    awaited_results [$];
    t_uart_item uart_bytes [$];
    t_result    want;

    bit drain_pending     = 1'b0;
    bit in_taken          = 1'b0;
    bit held_long         = 1'b0;
    int mismatches        = 0;
    int quiet_cycles      = 0;
    int results_seen      = 0;
    int tx_wait           = 0;
    int tx_burst          = 0;
    int rx_left           = 0;
    int rx_burst          = 0;
    int hold_left         = 0;
    int bytes_made        = 0;

    nmea_sentence_parser #(
        .MAX_LINE   (MAX_LINE),
        .MAX_FIELDS (MAX_FIELDS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_rx_byte         (i_rx_byte),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_sentence_kind   (o_sentence_kind),
        .o_status_active   (o_status_active),
        .o_time_ok         (o_time_ok),
        .o_hour            (o_hour),
        .o_minute          (o_minute),
        .o_second          (o_second),
        .o_date_ok         (o_date_ok),
        .o_day_of_month    (o_day_of_month),
        .o_month_number    (o_month_number),
        .o_year_in_century (o_year_in_century),
        .o_fix_type        (o_fix_type),
        .o_satellite_count (o_satellite_count)
    );

    always #4 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // sentence decoder prediction
    // ------------------------------------------------------------------
    task automatic open_sentence();
        foreach (fld_val[k]) fld_val[k] = 8'd0;
        line_len   = 8'd0;
        ck_sum     = 8'd0;
        ck_seen    = 8'd0;
        ck_state   = CK_BODY;
        fld_idx    = 5'd0;
        fld_pos    = 8'd0;
        msg_type   = ST_PREFIX;
        fld_val[V_RUN] = 8'd1;
        line_flags = 4'd0;
    endtask

    function automatic int hex_digit(input t_byte c);
        if (c >= "0" && c <= "9") return int'(c) - 48;
        if (c >= "A" && c <= "F") return int'(c) - 55;
        if (c >= "a" && c <= "f") return int'(c) - 87;
        return -1;
    endfunction

    // hhmmss / ddmmyy: pairs of digits, plain 8-bit arithmetic on any character
    task automatic pair_char(input int base, input t_byte c, input logic [3:0] flag);
        t_byte d;
        int    slot;
        if (fld_pos > 5) return;
        d = c - CH_ZERO;
        slot = base + int'(fld_pos >> 1);
        if (!fld_pos[0]) begin
            fld_val[slot] = d * 8'd10;
        end else begin
            fld_val[slot] = fld_val[slot] + d;
        end
        if (fld_pos == 5) line_flags |= flag;
    endtask

    task automatic run_char(input int slot, input t_byte c);
        int v;
        if (fld_val[V_RUN] != 0 && c >= "0" && c <= "9") begin
            v = int'(fld_val[slot]) * 10 + int'(c) - 48;
            fld_val[slot] = (v > 255) ? 8'hFF : t_byte'(v);
        end else begin
            fld_val[V_RUN] = 8'd0;
        end
    endtask

    task automatic decode_char(input t_byte c, input t_byte pos);
        int nib;
        if (pos == 1 && c != CH_G) msg_type = ST_OTHER;
        if (pos == 2 && c != CH_N && c != CH_P) msg_type = ST_OTHER;
        if (pos == 3 && msg_type == ST_PREFIX) begin
            msg_type = (c == CH_R) ? ST_RMC : (c == CH_G) ? ST_GGA : ST_OTHER;
        end
        if (pos == 4 && ((msg_type == ST_RMC && c != CH_M) || (msg_type == ST_GGA && c != CH_G)))
            msg_type = ST_OTHER;
        if (pos == 5 && ((msg_type == ST_RMC && c != CH_C) || (msg_type == ST_GGA && c != CH_A)))
            msg_type = ST_OTHER;

        if (pos != 0) begin
            if (ck_state == CK_BODY) begin
                if (c == CH_STAR) ck_state = CK_HEX;
                else ck_sum ^= c;
            end else if (ck_state == CK_HEX) begin
                nib = hex_digit(c);
                if (nib < 0) ck_state = CK_DONE;
                else ck_seen = {ck_seen[3:0], 4'(nib)};
            end
        end

        if (c == CH_COMMA && fld_idx < MAX_FIELDS - 1) begin
            fld_idx++;
            fld_pos = 8'd0;
            fld_val[V_RUN] = 8'd1;
            return;
        end
        case (int'(fld_idx))
            FLD_TIME:   pair_char(V_HOUR, c, F_TIME);
            FLD_STATUS: if (fld_pos == 0 && c == CH_A) line_flags |= F_STAT;
            FLD_FIX:    run_char(V_FIX, c);
            FLD_SATS:   run_char(V_SATS, c);
            FLD_DATE:   pair_char(V_DAY, c, F_DATE);
            default: begin
            end
        endcase
        if (fld_pos != 8'hFF) fld_pos++;
    endtask

    function automatic t_result finish_sentence();
        t_result r;
        r = '0;
        if ((line_flags & F_LONG) != 0 || ck_state == CK_BODY || ck_sum != ck_seen)
            r.kind = KIND_BAD_CK;
        else if (msg_type != ST_RMC && msg_type != ST_GGA)
            r.kind = KIND_OTHER;
        else if (int'(fld_idx) + 1 < MIN_FIELDS)
            r.kind = KIND_FEW;
        else
            r.kind = (msg_type == ST_RMC) ? KIND_RMC : KIND_GGA;

        // RMC reports nothing past a missing 'A' or a short time field
        if (r.kind == KIND_RMC && (line_flags & F_STAT) != 0) begin
            r.status_active = 1'b1;
            if ((line_flags & F_TIME) != 0) begin
                r.time_ok = 1'b1;
                r.hour    = fld_val[V_HOUR];
                r.minute  = fld_val[V_MIN];
                r.second  = fld_val[V_SEC];
                if ((line_flags & F_DATE) != 0) begin
                    r.date_ok = 1'b1;
                    r.day     = fld_val[V_DAY];
                    r.month   = fld_val[V_MON];
                    r.year    = fld_val[V_YEAR];
                end
            end
        end else if (r.kind == KIND_GGA) begin
            if ((line_flags & F_TIME) != 0) begin
                r.time_ok = 1'b1;
                r.hour    = fld_val[V_HOUR];
                r.minute  = fld_val[V_MIN];
                r.second  = fld_val[V_SEC];
            end
            r.fix  = fld_val[V_FIX];
            r.sats = fld_val[V_SATS];
        end
        return r;
    endfunction

    task automatic parse_char(input t_byte c);
        t_byte pos;
        if (c == CH_DOLLAR) begin
            open_sentence();
            in_line = 1'b1;
        end
        if (!in_line) return;
        if (line_len < MAX_LINE - 1) begin
            pos = line_len;
            line_len++;
            decode_char(c, pos);
        end else begin
            line_flags |= F_LONG;
        end
        if (c == CH_LF) begin
            awaited_results.push_back(finish_sentence());
            in_line = 1'b0;
        end
    endtask

    function automatic void check_field(input string name, input int unsigned exp_val,
                                        input int unsigned got_val);
        if (exp_val != got_val) begin
            $error("%s: expected %0d, got %0d", name, exp_val, got_val);
            mismatches++;
        end
    endfunction

    // ------------------------------------------------------------------
    // sentence construction
    // ------------------------------------------------------------------
    function automatic void add_text(ref t_byte q[$], input string s);
        for (int k = 0; k < s.len(); k++) q.push_back(t_byte'(s[k]));
    endfunction

    // any byte that cannot end the sentence, the body or the field
    function automatic t_byte any_char();
        t_byte c;
        do c = t_byte'($urandom_range(0, 255));
        while (c == CH_DOLLAR || c == CH_LF || c == CH_STAR || c == CH_COMMA);
        return c;
    endfunction

    function automatic void add_digits(ref t_byte q[$], input int n);
        for (int k = 0; k < n; k++) q.push_back(CH_ZERO + t_byte'($urandom_range(0, 9)));
    endfunction

    function automatic void add_junk(ref t_byte q[$], input int n);
        for (int k = 0; k < n; k++) q.push_back(any_char());
    endfunction

    function automatic void add_hex_digit(ref t_byte q[$], input logic [3:0] v, input bit lower);
        if (v < 10) q.push_back(CH_ZERO + t_byte'(v));
        else q.push_back(t_byte'(v) + (lower ? 8'h57 : 8'h37));
    endfunction

    function automatic void add_field(ref t_byte q[$], input t_field_role role);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        case (role)
            FR_CLOCK: begin
                if (pick < 80) begin
                    add_digits(q, 6);
                    if (pick < 50) begin
                        add_text(q, ".");
                        add_digits(q, $urandom_range(1, 3));
                    end
                end else if (pick < 90) begin
                    add_digits(q, $urandom_range(0, 5));
                end else begin
                    add_junk(q, $urandom_range(4, 8));
                end
            end
            FR_FLAG: begin
                if (pick < 60) add_text(q, "A");
                else if (pick < 85) add_text(q, "V");
                else if (pick >= 90) add_junk(q, $urandom_range(1, 2));
            end
            FR_COUNT: begin
                if (pick < 70) begin
                    add_digits(q, $urandom_range(1, 2));
                end else if (pick < 80) begin
                    // empty
                end else if (pick < 90) begin
                    add_digits(q, $urandom_range(3, 5));
                end else if (pick < 95) begin
                    add_junk(q, 1);
                    add_digits(q, $urandom_range(1, 2));
                end else begin
                    add_digits(q, $urandom_range(1, 2));
                    add_junk(q, $urandom_range(1, 2));
                    add_digits(q, 1);
                end
            end
            default: begin
                if (pick < 50) begin
                    add_digits(q, $urandom_range(1, 5));
                    add_text(q, ".");
                    add_digits(q, $urandom_range(1, 3));
                end else if (pick < 70) begin
                    // empty
                end else if (pick < 85) begin
                    q.push_back(CH_A + t_byte'($urandom_range(0, 25)));
                end else begin
                    add_junk(q, $urandom_range(1, 6));
                end
            end
        endcase
    endfunction

    function automatic void random_body(ref t_byte q[$]);
        int unsigned pick;
        int          total;
        bit          rmc_layout;
        string       head;
        pick = $urandom_range(0, 99);
        rmc_layout = $urandom_range(0, 1);
        if (pick < 40) begin
            head = $urandom_range(0, 1) ? "GNRMC" : "GPRMC";
            rmc_layout = 1'b1;
        end else if (pick < 75) begin
            head = $urandom_range(0, 1) ? "GNGGA" : "GPGGA";
            rmc_layout = 1'b0;
        end else if (pick < 88) begin
            case ($urandom_range(0, 3))
                0: head = "GPGSV";
                1: head = "GNGSA";
                2: head = "GPVTG";
                default: head = "GNGLL";
            endcase
        end else begin
            // one letter of a known header swapped out
            head = rmc_layout ? "GPRMC" : "GNGGA";
            head.putc($urandom_range(0, 4), byte'(CH_A + t_byte'($urandom_range(0, 25))));
        end
        add_text(q, head);

        pick = $urandom_range(0, 99);
        if (pick < 85) total = rmc_layout ? 13 : 15;
        else if (pick < 93) total = $urandom_range(1, 9);
        else total = $urandom_range(20, 30);

        for (int f = 1; f < total; f++) begin
            q.push_back(CH_COMMA);
            if (f == FLD_TIME) add_field(q, FR_CLOCK);
            else if (f == FLD_STATUS && rmc_layout) add_field(q, FR_FLAG);
            else if ((f == FLD_FIX || f == FLD_SATS) && !rmc_layout) add_field(q, FR_COUNT);
            else if (f == FLD_DATE && rmc_layout) add_field(q, FR_CLOCK);
            else add_field(q, FR_FILL);
        end
        if ($urandom_range(0, 99) < 3) begin
            while (q.size() < 140) begin
                q.push_back(CH_COMMA);
                add_field(q, FR_FILL);
            end
        end
    endfunction

    function automatic t_tail pick_tail();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 80) return TAIL_GOOD;
        if (pick < 85) return TAIL_WRONG;
        if (pick < 89) return TAIL_NO_STAR;
        if (pick < 93) return TAIL_LOWER;
        if (pick < 97) return TAIL_EXTRA_DIGIT;
        return TAIL_ONE_DIGIT;
    endfunction

    function automatic void frame_sentence(ref t_byte body[$], input t_tail tail, input bit crlf,
                                           ref t_byte line[$]);
        t_byte sum;
        sum = 8'd0;
        line.push_back(CH_DOLLAR);
        foreach (body[k]) begin
            sum ^= body[k];
            line.push_back(body[k]);
        end
        if (tail == TAIL_WRONG) sum ^= t_byte'($urandom_range(1, 255));
        if (tail != TAIL_NO_STAR) begin
            line.push_back(CH_STAR);
            // a leading extra digit is shifted out of the 8-bit checksum
            if (tail == TAIL_EXTRA_DIGIT) add_hex_digit(line, 4'($urandom_range(0, 15)), 1'b0);
            if (tail != TAIL_ONE_DIGIT) add_hex_digit(line, sum[7:4], tail == TAIL_LOWER);
            add_hex_digit(line, sum[3:0], tail == TAIL_LOWER);
        end
        if (crlf) line.push_back(CH_CR);
        line.push_back(CH_LF);
    endfunction

    task automatic send_line(ref t_byte line[$]);
        t_uart_item it;
        foreach (line[k]) begin
            it.ch = line[k];
            it.drain_first = drain_pending;
            drain_pending = 1'b0;
            uart_bytes.push_back(it);
        end
        bytes_made += line.size();
    endtask

    task automatic send_fixed(input string text, input t_tail tail, input bit crlf);
        t_byte body[$];
        t_byte line[$];
        add_text(body, text);
        frame_sentence(body, tail, crlf, line);
        send_line(line);
    endtask

    task automatic send_raw(input string text);
        t_byte line[$];
        add_text(line, text);
        send_line(line);
    endtask

    task automatic directed_lines();
        t_byte body[$];
        t_byte line[$];
        // stray bytes outside a sentence, line feed included
        line = '{CH_LF, 8'h00, 8'hFF, 8'h7E, CH_COMMA};
        send_line(line);
        send_fixed("GPRMC,235959.00,A,4807.038,N,01131.000,E,022.4,084.4,311299,003.1,W",
                   TAIL_GOOD, 1'b1);
        send_fixed("GNRMC,000000,V,,,,,,,010100,,,N", TAIL_GOOD, 1'b0);
        send_fixed("GNGGA,123519,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,", TAIL_GOOD,
                   1'b1);
        // short time, saturating fix, sign ends the satellite run
        send_fixed("GPGGA,99,,,,,999,-3,,,,,,,", TAIL_LOWER, 1'b1);
        send_fixed("GPRMC,1234,A,,,,,,,311299,,", TAIL_GOOD, 1'b1);
        send_fixed("GPRMC,101010,A,,,,,,,020304,,", TAIL_WRONG, 1'b1);
        send_fixed("GPRMC,101010,A,,,,,,,020304,,", TAIL_NO_STAR, 1'b1);
        send_fixed("GPGSV,3,1,11,03,03,111,00", TAIL_GOOD, 1'b1);
        send_fixed("GNGGA,120000,,,,,2,05", TAIL_GOOD, 1'b1);
        send_fixed("GXRMC,101010,A,,,,,,,020304,,", TAIL_GOOD, 1'b1);
        send_fixed("GPGGX,101010,,,,,1,07,,,,,,,", TAIL_GOOD, 1'b1);
        send_fixed({"GPTXT,0123456789,0123456789,0123456789,0123456789,0123456789",
                    ",0123456789,0123456789,0123456789,0123456789,0123456789",
                    ",0123456789,0123456789,0123456789,0123456789"}, TAIL_GOOD, 1'b1);
        // sentence cut short by a fresh '$'
        send_raw("$GPRMC,1200");
        send_fixed("GPGGA,010203,,,,,255,256,,,,,,,", TAIL_EXTRA_DIGIT, 1'b1);
        // junk time digits, zero and all-ones bytes, more commas than fields
        add_text(body, "GPRMC,ab:cd:,A,,,,,,,9z9z9z");
        for (int k = 0; k < 15; k++) body.push_back(CH_COMMA);
        body.push_back(8'h00);
        body.push_back(8'hFF);
        line.delete();
        frame_sentence(body, TAIL_GOOD, 1'b1, line);
        send_line(line);
        send_fixed("GPRMC,070809,A,,,,,,,101112,,", TAIL_ONE_DIGIT, 1'b1);
        send_fixed("GNGGA,,,,,,,,,,,,,,", TAIL_GOOD, 1'b1);
    endtask

    // ------------------------------------------------------------------
    // gap lengths
    // ------------------------------------------------------------------
    function automatic int tx_gap();
        int unsigned pick;
        if (tx_burst > 0) begin
            tx_burst--;
            return 0;
        end
        pick = $urandom_range(0, 999);
        if (pick < 5) begin
            tx_burst = $urandom_range(100, 300);
            return 0;
        end
        if (pick < 650) return 0;
        if (pick < 900) return $urandom_range(1, 3);
        if (pick < 980) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int rx_free_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 3) return $urandom_range(100, 300);
        if (pick < 60) return $urandom_range(0, 3);
        return $urandom_range(4, 30);
    endfunction

    function automatic int rx_stall_len();
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 70) return $urandom_range(1, 2);
        if (pick < 95) return $urandom_range(3, 10);
        return $urandom_range(20, 60);
    endfunction

    // ------------------------------------------------------------------
    // byte driver
    // ------------------------------------------------------------------
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && !in_taken) begin
            // item still offered, payload held
        end else if (tx_wait != 0) begin
            tx_wait--;
            i_in_valid <= 1'b0;
        end else if (uart_bytes.size() == 0 ||
                     (uart_bytes[0].drain_first && awaited_results.size() != 0)) begin
            i_in_valid <= 1'b0;
        end else begin
            i_in_valid <= 1'b1;
            i_rx_byte  <= uart_bytes[0].ch;
            tx_wait = tx_gap();
        end
    end

    // result receiver stalls, with one long hold-off to back up the parser
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_stall <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (!held_long && results_seen >= 10) begin
            held_long = 1'b1;
            hold_left = LONG_HOLD;
            i_out_stall <= 1'b1;
        end else if (rx_left != 0) begin
            rx_left--;
        end else if (i_out_stall) begin
            i_out_stall <= 1'b0;
            rx_left = rx_free_len();
        end else begin
            i_out_stall <= 1'b1;
            rx_left = rx_stall_len() - 1;
        end
    end

    // ------------------------------------------------------------------
    // monitor: checks results, predicts from accepted bytes, watchdog
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        in_taken = 1'b0;
        if (i_rst_n) begin
            quiet_cycles++;
            if (o_out_valid && !i_out_stall) begin
                quiet_cycles = 0;
                results_seen++;
                if (awaited_results.size() == 0) begin
                    $error("sentence_kind %0d: result item with no sentence pending",
                           o_sentence_kind);
                    mismatches++;
                end else begin
                    want = awaited_results.pop_front();
                    check_field("sentence_kind", want.kind, o_sentence_kind);
                    check_field("status_active", want.status_active, o_status_active);
                    check_field("time_ok", want.time_ok, o_time_ok);
                    check_field("hour", want.hour, o_hour);
                    check_field("minute", want.minute, o_minute);
                    check_field("second", want.second, o_second);
                    check_field("date_ok", want.date_ok, o_date_ok);
                    check_field("day_of_month", want.day, o_day_of_month);
                    check_field("month_number", want.month, o_month_number);
                    check_field("year_in_century", want.year, o_year_in_century);
                    check_field("fix_type", want.fix, o_fix_type);
                    check_field("satellite_count", want.sats, o_satellite_count);
                end
            end
            if (i_in_valid && !o_in_stall) begin
                quiet_cycles = 0;
                parse_char(i_rx_byte);
                void'(uart_bytes.pop_front());
                in_taken = 1'b1;
            end
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("nmea_sentence_parser_tb: done, errors");
                $finish;
            end
        end
    end

    initial begin
        t_byte body[$];
        t_byte line[$];
        directed_lines();
        drain_pending = 1'b1;
        while (bytes_made < 1850) begin
            body.delete();
            line.delete();
            if ($urandom_range(0, 99) < 15) begin
                // noise ahead of the sentence; no '$', so it starts no sentence
                repeat ($urandom_range(1, 6)) begin
                    line.push_back(t_byte'($urandom_range(0, 255)));
                    if (line[$] == CH_DOLLAR) line[$] = CH_LF;
                end
            end
            random_body(body);
            frame_sentence(body, pick_tail(), $urandom_range(0, 4) != 0, line);
            if ($urandom_range(0, 99) < 5) line = line[0:$urandom_range(1, line.size() - 2)];
            if ($urandom_range(0, 99) < 3) drain_pending = 1'b1;
            send_line(line);
        end

        repeat (6) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (uart_bytes.size() != 0 || awaited_results.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("nmea_sentence_parser_tb: done, clean");
        end else begin
            $display("nmea_sentence_parser_tb: done, errors");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
hw/rtl/nsp_pkg.sv
hw/rtl/nsp_result.sv
hw/rtl/nmea_sentence_parser.sv
dv/nmea_sentence_parser_tb.sv
